FILE: src/mbps_pkg.sv
// shared constants, register codes and structs of the masked byte pattern scanner
`timescale 1ns / 1ps
package mbps_pkg;

  localparam int PATTERN_MAX_DEF = 16;  // default window depth
  localparam int PAT_BYTES       = 16;  // pattern bytes held by the registers
  localparam int LEN_W           = 5;
  localparam int ADDR_W          = 48;
  localparam int RES_W           = 64;
  localparam int BASE_W          = 48;
  localparam int IGN_W           = 16;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PAT_LO     = 3'd0,
    REG_PAT_HI     = 3'd1,
    REG_IGN_MASK   = 3'd2,
    REG_PAT_LEN    = 3'd3,
    REG_RES_OFFSET = 3'd4,
    REG_MOD_BASE   = 3'd5
  } reg_idx_t;

  // settings that the window compare needs
  typedef struct packed {
    logic [PAT_BYTES*8-1:0] pattern;
    logic [IGN_W-1:0]       ignore;
    logic [LEN_W-1:0]       len;    // clamped to 1..PATTERN_MAX
  } match_cfg_t;

  // the item held between the input register and the result register
  typedef struct packed {
    logic             valid;
    logic             hit;    // window matches and the region is long enough
    logic             fst;    // first beat of a scan
    logic             lst;    // last beat of a scan
    logic [RES_W-1:0] start;  // match start address, wrapped to 64 bits
  } win_stage_t;

endpackage

FILE: src/mbps_if.sv
// valid/ready channels for scanned bytes and for results
`timescale 1ns / 1ps
interface mbps_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic [47:0] byte_address;
  logic        region_first;
  logic        scan_begin;
  logic        scan_last;

  modport source (output valid, data_byte, byte_address, region_first, scan_begin,
                  scan_last, input ready);
  modport sink (input valid, data_byte, byte_address, region_first, scan_begin,
                scan_last, output ready);
endinterface

interface mbps_out_if;
  logic               valid;
  logic               ready;
  logic               found;
  logic signed [63:0] match_address;

  modport source (output valid, found, match_address, input ready);
  modport sink (input valid, found, match_address, output ready);
endinterface

FILE: src/mbps_cfg.sv
// configuration registers with the clamped length and the offset minus base term
`timescale 1ns / 1ps
module mbps_cfg #(
  parameter int PATTERN_MAX = mbps_pkg::PATTERN_MAX_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [mbps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mbps_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output mbps_pkg::match_cfg_t            mcfg,
  output logic [mbps_pkg::RES_W-1:0]      delta
);
  import mbps_pkg::*;

  logic [63:0]        pat_lo_r;
  logic [63:0]        pat_hi_r;
  logic [IGN_W-1:0]   ign_r;
  logic [LEN_W-1:0]   len_r;
  logic [RES_W-1:0]   off_r;
  logic [BASE_W-1:0]  base_r;
  logic [RES_W-1:0]   delta_r;
  logic [RES_W-1:0]   delta_nxt;
  logic [LEN_W-1:0]   len_use_r;
  logic [LEN_W-1:0]   len_use_nxt;

  always_comb begin
    if (len_r == '0) begin
      len_use_nxt = LEN_W'(1);
    end else if (len_r > LEN_W'(PATTERN_MAX)) begin
      len_use_nxt = LEN_W'(PATTERN_MAX);
    end else begin
      len_use_nxt = len_r;
    end
    delta_nxt = off_r - {{(RES_W-BASE_W){1'b0}}, base_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_lo_r  <= '0;
      pat_hi_r  <= '0;
      ign_r     <= '0;
      len_r     <= LEN_W'(1);
      off_r     <= '0;
      base_r    <= '0;
      delta_r   <= '0;
      len_use_r <= LEN_W'(1);
    end else begin
      delta_r   <= delta_nxt;
      len_use_r <= len_use_nxt;
      if (cfg_we) begin
        case (reg_idx_t'(cfg_index))
          REG_PAT_LO:     pat_lo_r <= cfg_wdata;
          REG_PAT_HI:     pat_hi_r <= cfg_wdata;
          REG_IGN_MASK:   ign_r    <= cfg_wdata[IGN_W-1:0];
          REG_PAT_LEN:    len_r    <= cfg_wdata[LEN_W-1:0];
          REG_RES_OFFSET: off_r    <= cfg_wdata;
          REG_MOD_BASE:   base_r   <= cfg_wdata[BASE_W-1:0];
          default: ;
        endcase
      end
    end
  end

  assign mcfg.pattern = {pat_hi_r, pat_lo_r};
  assign mcfg.ignore  = ign_r;
  assign mcfg.len     = len_use_r;
  assign delta        = delta_r;

endmodule

FILE: src/mbps_win.sv
// byte window, region fill count, input register and masked window compare
`timescale 1ns / 1ps
module mbps_win #(
  parameter int PATTERN_MAX = mbps_pkg::PATTERN_MAX_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          load,
  input  logic                          adv,
  input  logic [7:0]                    data_byte,
  input  logic [mbps_pkg::ADDR_W-1:0]   byte_address,
  input  logic                          region_first,
  input  logic                          scan_begin,
  input  logic                          scan_last,
  input  mbps_pkg::match_cfg_t          mcfg,
  output mbps_pkg::win_stage_t          stage
);
  import mbps_pkg::*;

  localparam int IDX_W  = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int FILL_W = $clog2(PATTERN_MAX + 1);

  logic [7:0]        win_r   [PATTERN_MAX];
  logic [7:0]        win_nxt [PATTERN_MAX];
  logic [FILL_W-1:0] fill_r;
  logic [FILL_W-1:0] fill_nxt;
  logic              valid_r;
  logic              fst_r;
  logic              lst_r;
  logic [RES_W-1:0]  start_r;
  logic [RES_W-1:0]  start_nxt;
  logic              clr;
  logic              cmp_ok;
  logic [IDX_W-1:0]  idx;

  assign clr = region_first | scan_begin;

  always_comb begin
    for (int i = PATTERN_MAX - 1; i > 0; i--) begin
      win_nxt[i] = clr ? 8'h00 : win_r[i-1];
    end
    win_nxt[0] = data_byte;
    if (clr) begin
      fill_nxt = FILL_W'(1);
    end else if (fill_r < FILL_W'(PATTERN_MAX)) begin
      fill_nxt = fill_r + FILL_W'(1);
    end else begin
      fill_nxt = fill_r;
    end
    start_nxt = {{(RES_W-ADDR_W){1'b0}}, byte_address}
              - RES_W'(mcfg.len - LEN_W'(1));
  end

  // pattern byte k is checked against the k-th oldest of the last len bytes
  always_comb begin
    cmp_ok = 1'b1;
    idx    = '0;
    for (int k = 0; k < PATTERN_MAX; k++) begin
      idx = IDX_W'(mcfg.len - LEN_W'(k + 1));
      if (LEN_W'(k) < mcfg.len && !mcfg.ignore[k]) begin
        if (win_r[idx] != mcfg.pattern[8*k +: 8]) begin
          cmp_ok = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      fill_r  <= '0;
      for (int i = 0; i < PATTERN_MAX; i++) begin
        win_r[i] <= 8'h00;
      end
    end else begin
      if (load) begin
        valid_r <= 1'b1;
        fill_r  <= fill_nxt;
        win_r   <= win_nxt;
      end else if (adv) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      fst_r   <= scan_begin;
      lst_r   <= scan_last;
      start_r <= start_nxt;
    end
  end

  assign stage.valid = valid_r;
  assign stage.hit   = cmp_ok && (LEN_W'(fill_r) >= mcfg.len);
  assign stage.fst   = fst_r;
  assign stage.lst   = lst_r;
  assign stage.start = start_r;

endmodule

FILE: src/masked_byte_pattern_scanner_top.sv
// Masked byte pattern scanner. One byte beat is taken per cycle as long as results are taken.
// Each beat first sits in the input register, where the window of the last PATTERN_MAX bytes
// of the region is compared with the pattern under the ignore mask; a result, if any, is then
// held in the result register. The first match of a scan gives found=1 with match start +
// offset - base (mod 2^64); a scan that ends with no match gives found=0 and a zero address;
// all other beats give no result. Configuration writes go into the registers; the clamped
// length and the offset minus base term are registered once more behind them.
`timescale 1ns / 1ps
module masked_byte_pattern_scanner_top #(
  parameter int PATTERN_MAX = mbps_pkg::PATTERN_MAX_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  mbps_in_if.sink                         in_ch,
  mbps_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [mbps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mbps_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import mbps_pkg::*;

  match_cfg_t        mcfg;
  logic [RES_W-1:0]  delta;
  win_stage_t        stage;
  logic              load;
  logic              adv;
  logic              seen_r;
  logic              seen_eff;
  logic              seen_nxt;
  logic              hit;
  logic              emit;
  logic              out_valid_r;
  logic              out_valid_nxt;
  logic              out_found_r;
  logic [RES_W-1:0]  out_addr_r;

  mbps_cfg #(.PATTERN_MAX(PATTERN_MAX)) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .mcfg      (mcfg),
    .delta     (delta)
  );

  mbps_win #(.PATTERN_MAX(PATTERN_MAX)) u_win (
    .clk          (clk),
    .rst_n        (rst_n),
    .load         (load),
    .adv          (adv),
    .data_byte    (in_ch.data_byte),
    .byte_address (in_ch.byte_address),
    .region_first (in_ch.region_first),
    .scan_begin   (in_ch.scan_begin),
    .scan_last    (in_ch.scan_last),
    .mcfg         (mcfg),
    .stage        (stage)
  );

  assign adv         = stage.valid && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !stage.valid || adv;
  assign load        = in_ch.valid && in_ch.ready;

  // a scan start forgets any earlier match
  assign seen_eff = stage.fst ? 1'b0 : seen_r;
  assign hit      = stage.hit && !seen_eff;
  assign emit     = hit || (stage.lst && !seen_eff);
  assign seen_nxt = seen_eff | hit | stage.lst;

  always_comb begin
    if (adv) begin
      out_valid_nxt = emit;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (adv) begin
        seen_r <= seen_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && emit) begin
      out_found_r <= hit;
      out_addr_r  <= hit ? (stage.start + delta) : '0;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.found         = out_found_r;
  assign out_ch.match_address = out_addr_r;

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> stage.valid && out_valid_r && !out_ch.ready)
    else $error("input stalled without a full pipeline");

  a_seen_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
    adv && emit |=> seen_r)
    else $error("result given but scan not marked as done");

  a_no_second_result: assert property (@(posedge clk) disable iff (!rst_n)
    adv && !stage.fst && seen_r |-> !emit)
    else $error("second result within one scan");

  a_notfound_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_found_r |-> out_addr_r == '0)
    else $error("not-found beat carries an address");

endmodule
